### design/htd_pkg.sv
// Shared types and constants for the Huffman tree decoder.
// Used by htd_node_ram, htd_walker and huffman_tree_decoder_top; no dependencies.
package htd_pkg;

  localparam int IDX_BITS       = 9;
  localparam int SYM_BITS       = 8;
  localparam int BYTE_BITS      = 8;
  localparam int TOTAL_BITS     = 24;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 24;
  localparam int BIT_CNT_BITS   = 4;

  // Bits consumed from one code byte, most significant first.
  localparam logic [BIT_CNT_BITS-1:0] BITS_PER_BYTE = 4'd8;
  localparam logic [BYTE_BITS-1:0]    BYTE_TOP      = 8'h80;

  // Command codes of an input item.
  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_DECODE  = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_SYMBOL_TOTAL = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ROOT_INDEX   = 2'd1;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [IDX_BITS-1:0] node_index;
    logic [IDX_BITS-1:0] left_child;
    logic [IDX_BITS-1:0] right_child;
    logic                is_leaf;
    logic [SYM_BITS-1:0] leaf_symbol;
    logic [BYTE_BITS-1:0] code_byte;
  } in_item_t;

  typedef struct packed {
    logic [SYM_BITS-1:0] symbol;
    logic                last_of_byte;
    logic                stream_done;
  } out_item_t;

  typedef struct packed {
    logic [IDX_BITS-1:0] left;
    logic [IDX_BITS-1:0] right;
    logic                leaf;
    logic [SYM_BITS-1:0] sym;
  } node_t;

  typedef struct packed {
    logic [TOTAL_BITS-1:0] symbol_total;
    logic [IDX_BITS-1:0]   root_index;
  } cfg_t;

  // Request from the walker to the node table.
  typedef struct packed {
    logic                rd_en;
    logic [IDX_BITS-1:0] rd_idx;
    logic                wr_en;
    logic [IDX_BITS-1:0] wr_idx;
    node_t               wr_node;
  } ram_req_t;

endpackage

### design/htd_node_ram.sv
// Node table: one write port and one registered read port.
// Depends on htd_pkg. Indexes at or beyond NODE_COUNT write nothing and read as zero.
module htd_node_ram #(
  parameter int NODE_COUNT = 512
) (
  input  logic              clk,
  input  htd_pkg::ram_req_t req,
  output htd_pkg::node_t    rd_node
);

  localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  htd_pkg::node_t mem [NODE_COUNT];

  logic wr_in_range;
  logic rd_in_range;

  assign wr_in_range = 32'(req.wr_idx) < NODE_COUNT;
  assign rd_in_range = 32'(req.rd_idx) < NODE_COUNT;

  always_ff @(posedge clk) begin
    if (req.wr_en && wr_in_range) begin
      mem[AW'(req.wr_idx)] <= req.wr_node;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      if (rd_in_range) begin
        rd_node <= mem[AW'(req.rd_idx)];
      end else begin
        rd_node <= '0;
      end
    end
  end

endmodule

### design/htd_walker.sv
// Sequencer that walks the code tree one bit per step and queues decoded symbols.
// Depends on htd_pkg; drives the node table request consumed by htd_node_ram.
module htd_walker #(
  parameter int COUNT_BITS = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  htd_pkg::cfg_t       cfg,
  input  htd_pkg::in_item_t   item,
  input  logic                item_valid,
  output logic                item_ready,
  output htd_pkg::out_item_t  result,
  output logic                result_valid,
  input  logic                result_ready,
  output htd_pkg::ram_req_t   ram_req,
  input  htd_pkg::node_t      rd_node
);

  typedef enum logic [1:0] {ST_IDLE, ST_STEP, ST_TEST, ST_DRAIN} state_t;

  state_t                              state;
  logic [htd_pkg::IDX_BITS-1:0]        walk;
  logic [COUNT_BITS-1:0]               count;
  logic [htd_pkg::BIT_CNT_BITS-1:0]    bit_cnt;
  logic [htd_pkg::BYTE_BITS-1:0]       shreg;
  logic                                pend_v;
  logic [htd_pkg::SYM_BITS-1:0]        pend_sym;
  logic                                pend_done;

  logic                                accept;
  logic                                restart_acc;
  logic [COUNT_BITS-1:0]               total;
  logic [COUNT_BITS-1:0]               count_next;
  logic                                go;
  logic                                out_free;
  logic                                can_emit;
  logic                                load_out;
  logic [htd_pkg::IDX_BITS-1:0]        child;

  assign item_ready  = (state == ST_IDLE);
  assign accept      = item_valid && item_ready;
  assign restart_acc = accept && (item.cmd == htd_pkg::CMD_RESTART);
  assign total       = COUNT_BITS'(cfg.symbol_total);
  assign count_next  = count + COUNT_BITS'(1);
  assign go          = (bit_cnt != htd_pkg::BITS_PER_BYTE) && (count < total);
  assign out_free    = !result_valid || result_ready;
  assign can_emit    = !pend_v || out_free;
  assign child       = ((shreg & htd_pkg::BYTE_TOP) != '0) ? rd_node.right : rd_node.left;

  // The output register is loaded when a held symbol moves out, either because a newer
  // leaf of the same byte was found or because the byte is finished.
  assign load_out = ((state == ST_TEST) && rd_node.leaf && can_emit && pend_v) ||
                    ((state == ST_DRAIN) && pend_v && out_free);

  // Node table requests. The read data register holds its value when no read is issued,
  // so a leaf waiting for the output stays in view; a node reached at a byte end is kept in walk.
  always_comb begin
    ram_req              = '0;
    ram_req.wr_idx       = item.node_index;
    ram_req.wr_node.left  = item.left_child;
    ram_req.wr_node.right = item.right_child;
    ram_req.wr_node.leaf  = item.is_leaf;
    ram_req.wr_node.sym   = item.leaf_symbol;
    ram_req.rd_idx       = walk;
    case (state)
      ST_IDLE: begin
        ram_req.wr_en  = accept && (item.cmd == htd_pkg::CMD_LOAD);
        ram_req.rd_en  = accept && (item.cmd == htd_pkg::CMD_DECODE);
        ram_req.rd_idx = walk;
      end
      ST_STEP: begin
        ram_req.rd_en  = go;
        ram_req.rd_idx = child;
      end
      ST_TEST: begin
        if (rd_node.leaf) begin
          ram_req.rd_en  = can_emit;
          ram_req.rd_idx = cfg.root_index;
        end else begin
          ram_req.rd_en  = go;
          ram_req.rd_idx = child;
        end
      end
      default: begin
        ram_req.rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      walk         <= '0;
      count        <= '0;
      bit_cnt      <= '0;
      pend_v       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= load_out || (result_valid && !result_ready);
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (item.cmd)
              htd_pkg::CMD_DECODE: begin
                shreg   <= item.code_byte;
                bit_cnt <= '0;
                state   <= ST_STEP;
              end
              htd_pkg::CMD_RESTART: begin
                count <= '0;
                walk  <= cfg.root_index;
              end
              default: begin
              end
            endcase
          end
        end
        ST_STEP: begin
          if (go) begin
            walk    <= child;
            bit_cnt <= bit_cnt + 1'b1;
            shreg   <= shreg << 1;
            state   <= ST_TEST;
          end else begin
            state <= ST_DRAIN;
          end
        end
        ST_TEST: begin
          if (rd_node.leaf) begin
            // An earlier symbol of this byte moves to the output first; wait if it is full.
            if (can_emit) begin
              if (pend_v) begin
                result.symbol       <= pend_sym;
                result.last_of_byte <= 1'b0;
                result.stream_done  <= pend_done;
              end
              pend_v    <= 1'b1;
              pend_sym  <= rd_node.sym;
              pend_done <= (count_next == total);
              count     <= count_next;
              walk      <= cfg.root_index;
              state     <= ST_STEP;
            end
          end else if (go) begin
            walk    <= child;
            bit_cnt <= bit_cnt + 1'b1;
            shreg   <= shreg << 1;
          end else begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!pend_v) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            result.symbol       <= pend_sym;
            result.last_of_byte <= 1'b1;
            result.stream_done  <= pend_done;
            pend_v              <= 1'b0;
            state               <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> (count == '0 || count == $past(count) + COUNT_BITS'(1)))
    else $error("symbol count moved by more than one");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_v)
    else $error("pending symbol left behind at end of byte");

  a_bit_cnt_range: assert property (@(posedge clk) disable iff (rst)
    bit_cnt <= htd_pkg::BITS_PER_BYTE)
    else $error("bit counter ran past the byte");

  a_walk_idle_stable: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && !restart_acc) |=> $stable(walk))
    else $error("walk position changed while idle");

endmodule

### design/huffman_tree_decoder_top.sv
// Huffman tree decoder: a decode item walks the stored tree one bit per cycle while no
// result waits, refetches the root for each leaf reached, then sees the byte finished and
// flushes the last symbol. The walk is paced by the single node table read port and stops
// early once the total is reached. Synchronous reset clears the count, walk position, state,
// valid flags and configuration registers; the node table is not cleared and reads undefined
// until written.
module huffman_tree_decoder_top #(
  parameter int NODE_COUNT = 512,
  parameter int COUNT_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  htd_pkg::in_item_t                     item,
  input  logic                                  item_valid,
  output logic                                  item_ready,
  output htd_pkg::out_item_t                    result,
  output logic                                  result_valid,
  input  logic                                  result_ready,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [htd_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [htd_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  // Configuration registers. The user must write them only while the decoder is idle; the
  // block does not enforce this. cfg_ready is tied high; an index beyond the list is dropped.
  htd_pkg::cfg_t     cfg;
  htd_pkg::ram_req_t ram_req;
  htd_pkg::node_t    rd_node;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        htd_pkg::REG_SYMBOL_TOTAL: begin
          cfg.symbol_total <= cfg_data[htd_pkg::TOTAL_BITS-1:0];
        end
        htd_pkg::REG_ROOT_INDEX: begin
          cfg.root_index <= cfg_data[htd_pkg::IDX_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // The walker sequences each item and owns the output register; the node table
  // answers one read per cycle from a registered read port, with the data in the next cycle.
  htd_walker #(
    .COUNT_BITS(COUNT_BITS)
  ) u_walker (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item         (item),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .ram_req      (ram_req),
    .rd_node      (rd_node)
  );

  htd_node_ram #(
    .NODE_COUNT(NODE_COUNT)
  ) u_node_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_node (rd_node)
  );

endmodule
